// ----- hdl/dbbc_pkg.sv -----
// dbbc_pkg: shared widths, constants, types and the rate clamp function
// for the delay based bitrate controller; no dependencies
package dbbc_pkg;

    localparam int unsigned TIME_W       = 64;
    localparam int unsigned RATE_W       = 32;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned IN_TDATA_W   = 2 * TIME_W;
    localparam int unsigned OUT_TDATA_W  = 40;

    localparam logic [RATE_W-1:0] DEFAULT_MIN_RATE = 32'd500000;
    localparam logic [RATE_W-1:0] MIN_INCREASE     = 32'd1000;
    localparam logic [TIME_W-1:0] OVERUSE_MARGIN   = 64'd15000;

    // floor(y/5) for y below 2^34 is (y * DIV5_RECIP) >> DIV5_SHIFT
    localparam int unsigned       DIV5_SHIFT = 35;
    localparam int unsigned       RECIP_W    = 33;
    localparam logic [RECIP_W-1:0] DIV5_RECIP = 33'd6871947674;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RATE   = 2'd0,
        CFG_MAX_RATE   = 2'd1,
        CFG_START_RATE = 2'd2
    } t_cfg_idx;

    // effective bounds, prepared from the configuration registers
    typedef struct packed {
        logic [RATE_W-1:0] eff_min;
        logic [RATE_W-1:0] max_rate;
        logic [RATE_W-1:0] init_rate;
    } t_bounds;

    // clamp: a nonzero upper bound wins, then the lower bound
    function automatic logic [RATE_W-1:0] bound_rate(
        input logic [RATE_W-1:0] v,
        input logic [RATE_W-1:0] lo,
        input logic [RATE_W-1:0] hi
    );
        logic [RATE_W-1:0] res;
        if (hi != '0 && v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- hdl/dbbc_delay.sv -----
// dbbc_delay: input register stage computing the one-way delay of a packet
// depends on dbbc_pkg
module dbbc_delay
    import dbbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [TIME_W-1:0] i_send_time,
    input  logic [TIME_W-1:0] i_recv_time,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [TIME_W-1:0] o_delay
);

    logic              r_vld;
    logic [TIME_W-1:0] r_delay;
    logic [TIME_W-1:0] n_delay;
    logic [TIME_W:0]   w_diff;
    logic              w_load;

    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    // receive minus send, forced to one when not positive
    always_comb begin
        w_diff = {1'b0, i_recv_time} - {1'b0, i_send_time};
        if (w_diff[TIME_W] || w_diff[TIME_W-1:0] == '0) begin
            n_delay = TIME_W'(1);
        end else begin
            n_delay = w_diff[TIME_W-1:0];
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // delay payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_delay <= n_delay;
        end
    end

    assign o_vld   = r_vld;
    assign o_delay = r_delay;

`ifndef ASSERT_OFF
    a_delay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_delay != '0)
        else $error("delay stage loaded a zero delay");
`endif

endmodule

// ----- hdl/dbbc_ovr.sv -----
// dbbc_ovr: tracks lowest and previous delay and flags delay overuse
// depends on dbbc_pkg
module dbbc_ovr
    import dbbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [TIME_W-1:0] i_delay,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic              o_over
);

    logic              r_vld;
    logic              r_over;
    logic [TIME_W-1:0] r_low;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W:0]   w_diff;
    logic              w_below;
    logic              n_over;
    logic              w_load;

    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    // overuse only when a lowest delay exists and the new one is well above it
    always_comb begin
        w_diff  = {1'b0, i_delay} - {1'b0, r_low};
        w_below = w_diff[TIME_W];
        n_over  = (r_low != '0) && !w_below
                  && (w_diff[TIME_W-1:0] > OVERUSE_MARGIN)
                  && (i_delay >= r_prev);
    end

    // valid and delay history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_low  <= '0;
            r_prev <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (w_load) begin
                if (r_low == '0 || w_below) begin
                    r_low <= i_delay;
                end
                r_prev <= i_delay;
            end
        end
    end

    // overuse flag payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_over <= n_over;
        end
    end

    assign o_vld  = r_vld;
    assign o_over = r_over;

`ifndef ASSERT_OFF
    a_low_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_low != '0)
        else $error("lowest delay still unset after a packet");
    a_low_le_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_low <= r_prev)
        else $error("lowest delay above the last delay");
`endif

endmodule

// ----- hdl/dbbc_rate.sv -----
// dbbc_rate: target rate update (multiplicative decrease or additive
// increase), clamp, and the result register; depends on dbbc_pkg
module dbbc_rate
    import dbbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bounds           i_bounds,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic              i_over,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [RATE_W-1:0] o_target_rate,
    output logic              o_overuse_seen
);

    localparam int unsigned NUM_W  = RATE_W + 2;
    localparam int unsigned PROD_W = RATE_W + RECIP_W;

    logic              r_vld;
    logic              r_primed;
    logic [RATE_W-1:0] r_target;
    logic              r_over;
    logic [RATE_W-1:0] n_target;
    logic [RATE_W-1:0] w_cur;
    logic [NUM_W-1:0]  w_num;
    logic [RATE_W-1:0] w_quarter;
    logic [PROD_W-1:0] w_prod;
    logic [RATE_W-1:0] w_quo;
    logic [RATE_W-1:0] w_inc;
    logic [RATE_W:0]   w_sum;
    logic [RATE_W-1:0] w_up;
    logic [RATE_W-1:0] w_dn;
    logic              w_load;

    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    // one shared divide by 20: decrease uses t - floor((3t+9)/20),
    // which equals round(17t/20); increase uses floor((t+10)/20)
    always_comb begin
        w_cur = r_primed ? r_target : i_bounds.init_rate;
        if (i_over) begin
            w_num = NUM_W'(w_cur) + {1'b0, w_cur, 1'b0} + NUM_W'(9);
        end else begin
            w_num = NUM_W'(w_cur) + NUM_W'(10);
        end
        w_quarter = w_num[NUM_W-1:2];
        w_prod    = PROD_W'(w_quarter) * PROD_W'(DIV5_RECIP);
        w_quo     = RATE_W'(w_prod[PROD_W-1:DIV5_SHIFT]);
        w_inc     = (w_quo < MIN_INCREASE) ? MIN_INCREASE : w_quo;
        w_sum     = {1'b0, w_cur} + {1'b0, w_inc};
        w_up      = w_sum[RATE_W] ? '1 : w_sum[RATE_W-1:0];
        w_dn      = w_cur - w_quo;
        n_target  = bound_rate(i_over ? w_dn : w_up, i_bounds.eff_min,
                               i_bounds.max_rate);
    end

    // valid, primed flag and the running target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_primed <= 1'b0;
            r_target <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (w_load) begin
                r_primed <= 1'b1;
                r_target <= n_target;
            end
        end
    end

    // overuse flag of the result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_over <= i_over;
        end
    end

    assign o_vld          = r_vld;
    assign o_target_rate  = r_target;
    assign o_overuse_seen = r_over;

`ifndef ASSERT_OFF
    a_target_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_target >= $past(i_bounds.eff_min)
                    || r_target == $past(i_bounds.max_rate)))
        else $error("target rate outside its bounds");
    a_primed_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_primed)
        else $error("primed flag not set after a packet");
`endif

endmodule

// ----- hdl/delay_based_bitrate_controller_core.sv -----
// path: a request passes the delay, overuse and rate stage registers in turn to m_tvalid
// throughput: one request per cycle while m_tready is high; the running target closes
// through one divide-by-20 multiplier and clamp inside the rate stage
// reset: synchronous active-low i_rst_n empties the pipeline, clears delay
// history and the target, and returns registers to min 500000, max 0, start 0
module delay_based_bitrate_controller_core
    import dbbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // send_time[63:0], recv_time[127:64]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // target_rate[31:0], overuse_seen[32], zero pad
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [RATE_W-1:0]      i_cfg_data
);

    logic [RATE_W-1:0] r_min_rate;
    logic [RATE_W-1:0] r_max_rate;
    logic [RATE_W-1:0] r_start_rate;
    t_bounds           r_bounds;
    t_bounds           n_bounds;

    logic              w_d_vld;
    logic              w_d_rdy;
    logic [TIME_W-1:0] w_delay;
    logic              w_o_vld;
    logic              w_o_rdy;
    logic              w_over;
    logic [RATE_W-1:0] w_target;
    logic              w_over_seen;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate   <= DEFAULT_MIN_RATE;
            r_max_rate   <= '0;
            r_start_rate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_RATE:   r_min_rate   <= i_cfg_data;
                CFG_MAX_RATE:   r_max_rate   <= i_cfg_data;
                CFG_START_RATE: r_start_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective bounds and clamped start rate, registered ahead of the rate stage
    always_comb begin
        n_bounds.eff_min   = (r_min_rate != '0) ? r_min_rate : DEFAULT_MIN_RATE;
        n_bounds.max_rate  = r_max_rate;
        n_bounds.init_rate = bound_rate(
            (r_start_rate != '0) ? r_start_rate : n_bounds.eff_min,
            n_bounds.eff_min, r_max_rate);
    end

    always_ff @(posedge i_clk) begin
        r_bounds <= n_bounds;
    end

    dbbc_delay u_delay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (s_tvalid),
        .o_rdy       (s_tready),
        .i_send_time (s_tdata[TIME_W-1:0]),
        .i_recv_time (s_tdata[IN_TDATA_W-1:TIME_W]),
        .o_vld       (w_d_vld),
        .i_rdy       (w_d_rdy),
        .o_delay     (w_delay)
    );

    dbbc_ovr u_ovr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_d_vld),
        .o_rdy   (w_d_rdy),
        .i_delay (w_delay),
        .o_vld   (w_o_vld),
        .i_rdy   (w_o_rdy),
        .o_over  (w_over)
    );

    dbbc_rate u_rate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bounds       (r_bounds),
        .i_vld          (w_o_vld),
        .o_rdy          (w_o_rdy),
        .i_over         (w_over),
        .o_vld          (m_tvalid),
        .i_rdy          (m_tready),
        .o_target_rate  (w_target),
        .o_overuse_seen (w_over_seen)
    );

    // result packing
    assign m_tdata = {{(OUT_TDATA_W - RATE_W - 1){1'b0}}, w_over_seen, w_target};

endmodule

// ----- tb/delay_based_bitrate_controller_core_tb.sv -----
// delay_based_bitrate_controller_core_tb: self-checking bench for the delay based
// bitrate controller; predicts every target rate and overuse flag and checks the stream
// depends on dbbc_pkg and delay_based_bitrate_controller_core
module delay_based_bitrate_controller_core_tb;
    import dbbc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic              overuse;
    } t_rate_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // send_time[63:0], recv_time[127:64]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // target_rate[31:0], overuse_seen[32], zero pad
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [RATE_W-1:0]      i_cfg_data;

    // shadow registers and controller state
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;
    logic [RATE_W-1:0] start_rate_reg;
    logic [TIME_W-1:0] seen_min_delay;
    logic [TIME_W-1:0] last_delay;
    logic [RATE_W-1:0] running_target;
    logic              primed_flag;

    t_rate_result pending_rates[$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_req_count;
    int           hold_seen_count;
    int           hold_left;

    delay_based_bitrate_controller_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // effective bounds applied to a candidate rate
    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] lo;
        lo = (min_rate_reg != '0) ? min_rate_reg : DEFAULT_MIN_RATE;
        if (max_rate_reg != '0 && v > max_rate_reg) begin
            return max_rate_reg;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // advance the controller by one packet and give the new target
    function automatic t_rate_result next_target_rate(input logic [TIME_W-1:0] snd,
                                                       input logic [TIME_W-1:0] rcv);
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] inc;
        logic [RATE_W-1:0] lo;
        logic              over;
        t_rate_result      res;
        dly = (rcv > snd) ? rcv - snd : '0;
        if (dly == '0) begin
            dly = 64'd1;
        end
        lo = (min_rate_reg != '0) ? min_rate_reg : DEFAULT_MIN_RATE;
        // first packet after reset loads the start rate
        if (!primed_flag) begin
            running_target = clamp_rate((start_rate_reg != '0) ? start_rate_reg : lo);
            primed_flag = 1'b1;
        end
        if (seen_min_delay == '0 || dly < seen_min_delay) begin
            seen_min_delay = dly;
        end
        over = (dly > seen_min_delay) && ((dly - seen_min_delay) > OVERUSE_MARGIN) &&
               (dly >= last_delay);
        t = {32'd0, running_target};
        if (over) begin
            t = (t * 17 + 10) / 20;
        end else begin
            inc = (t + 10) / 20;
            if (inc < MIN_INCREASE) begin
                inc = MIN_INCREASE;
            end
            t = t + inc;
            // saturate before clamping
            if (t > 64'hFFFF_FFFF) begin
                t = 64'hFFFF_FFFF;
            end
        end
        running_target = clamp_rate(t[RATE_W-1:0]);
        last_delay = dly;
        res.rate = running_target;
        res.overuse = over;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [RATE_W-1:0] got,
                                   input logic [RATE_W-1:0] want);
        $display("mismatch on %s: got %0d, wanted %0d at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    // offer one request and record its expected result once accepted
    task automatic send_packet(input logic [TIME_W-1:0] snd, input logic [TIME_W-1:0] rcv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rcv, snd};
        do begin
            @(negedge i_clk);
        end while (!s_tready);
        @(posedge i_clk);
        pending_rates.push_back(next_target_rate(snd, rcv));
    endtask

    task automatic send_with_delay(input logic [TIME_W-1:0] dly);
        logic [TIME_W-1:0] base;
        base = {1'b0, 31'($urandom), $urandom};
        send_packet(base, base + dly);
    endtask

    // stop offering and let every outstanding result come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_rates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [RATE_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_RATE:   min_rate_reg = val;
            CFG_MAX_RATE:   max_rate_reg = val;
            CFG_START_RATE: start_rate_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // first packet, timestamp extremes and the delay threshold
    task automatic test_first_packet();
        write_reg(CFG_START_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_RATE, 32'd0);
        write_reg(CFG_MAX_RATE, 32'd0);
        send_packet(64'd0, 64'd0);
        send_packet('1, '1);
        send_packet('1, 64'd0);
        send_packet(64'd0, '1);
        send_with_delay(64'd15001);
        send_with_delay(64'd15001);
        send_with_delay(64'd15002);
        send_with_delay(64'd15002);
        send_with_delay(64'd20000);
        send_with_delay(64'd19999);
        send_packet(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        wait_for_results();
    endtask

    // bound registers at their extremes, min above max included
    task automatic test_rate_bounds();
        write_reg(CFG_MAX_RATE, 32'd3000000);
        send_with_delay(64'd2);
        wait_for_results();
        write_reg(CFG_MIN_RATE, 32'hFFFF_FFFF);
        send_with_delay(64'd40000);
        send_with_delay(64'd2);
        wait_for_results();
        write_reg(CFG_MAX_RATE, 32'd0);
        send_with_delay(64'd2);
        send_with_delay(64'd2);
        wait_for_results();
        write_reg(CFG_MIN_RATE, 32'd1);
        write_reg(CFG_MAX_RATE, 32'd1);
        send_with_delay(64'd40000);
        wait_for_results();
        write_reg(CFG_MIN_RATE, 32'd0);
        send_with_delay(64'd2);
        wait_for_results();
        write_reg(CFG_MIN_RATE, 32'd1);
        write_reg(CFG_MAX_RATE, 32'd2000);
        send_with_delay(64'd2);
        wait_for_results();
        write_reg(CFG_MAX_RATE, 32'd0);
        send_with_delay(64'd40000);
        send_with_delay(64'd40000);
        send_with_delay(64'd2);
        send_with_delay(64'd40001);
        wait_for_results();
    endtask

    // mostly realistic delays around the threshold, some skewed and raw timestamps
    task automatic run_random_phase(input int count, input bit with_hold);
        int                kind;
        logic [TIME_W-1:0] snd;
        logic [TIME_W-1:0] rcv;
        logic [TIME_W-1:0] dly;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) begin
                hold_req_count++;
            end
            kind = $urandom_range(99);
            snd  = {$urandom, $urandom};
            if (kind < 80) begin
                if (kind < 12) begin
                    dly = 64'd15000 + TIME_W'($urandom_range(3));
                end else if (kind < 22) begin
                    dly = last_delay;
                end else begin
                    dly = TIME_W'($urandom_range(30000, 1));
                end
                rcv = snd + dly;
            end else if (kind < 90) begin
                rcv = snd - TIME_W'($urandom_range(1000));
            end else begin
                rcv = {$urandom, $urandom};
            end
            send_packet(snd, rcv);
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_MIN_RATE, 32'd0);
        write_reg(CFG_MAX_RATE, 32'd0);
        run_random_phase(270, 1'b1);
        send_idle_pct = 88;
        recv_idle_pct = 6;
        write_reg(CFG_MIN_RATE, 32'd1000000);
        write_reg(CFG_MAX_RATE, 32'd40000000);
        run_random_phase(270, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MIN_RATE, 32'd1);
        write_reg(CFG_MAX_RATE, 32'hFFFF_FFFF);
        run_random_phase(260, 1'b1);
    endtask

    // receiver ready, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req_count != hold_seen_count) begin
            hold_seen_count = hold_req_count;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker: outputs are stable at the falling edge
    always @(negedge i_clk) begin
        t_rate_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_rates.size() == 0) begin
                $display("result with no request waiting: %h at %0t", m_tdata, $realtime);
                mismatch_count++;
            end else begin
                want = pending_rates.pop_front();
                if (m_tdata[RATE_W-1:0] !== want.rate) begin
                    report_mismatch("target_rate", m_tdata[RATE_W-1:0], want.rate);
                end
                if (m_tdata[RATE_W] !== want.overuse) begin
                    report_mismatch("overuse_seen", {31'd0, m_tdata[RATE_W]},
                                    {31'd0, want.overuse});
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        m_tready       <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MIN_RATE;
        i_cfg_data     <= '0;
        min_rate_reg   = DEFAULT_MIN_RATE;
        max_rate_reg   = '0;
        start_rate_reg = '0;
        seen_min_delay = '0;
        last_delay     = '0;
        running_target = '0;
        primed_flag    = 1'b0;
        mismatch_count = 0;
        hold_req_count = 0;
        hold_seen_count = 0;
        hold_left      = 0;
        send_idle_pct  = 6;
        recv_idle_pct  = 88;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_packet();
        test_rate_bounds();
        test_random_traffic();
        if (mismatch_count == 0 && pending_rates.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #(12 * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule
